[design/rtst_pkg.sv]
// shared types and constants of the ranked top-k score table
package rtst_pkg;

  // command codes
  localparam logic [1:0] CmdAdd    = 2'd0;
  localparam logic [1:0] CmdLoad   = 2'd1;
  localparam logic [1:0] CmdSelect = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CfgCapacity    = 2'd0;
  localparam logic [1:0] CfgFreshChance = 2'd1;
  localparam logic [1:0] CfgDecayMode   = 2'd2;

  localparam int unsigned CfgWidth = 7;

  // register reset values
  localparam logic [4:0] CapacityReset    = 5'd16;
  localparam logic [6:0] FreshChanceReset = 7'd10;

  // fresh test works in percent
  localparam logic [6:0] FreshRange = 7'd100;

  // ceil(2^38 / 100), exact quotient by 100 for any 31-bit word after >> 38
  localparam logic [31:0] FreshRecip = 32'hA3D70A3E;

  localparam int unsigned ScoreBits = 32;
  localparam int unsigned RandBits  = 31;

  typedef enum logic [1:0] {
    CellHold,
    CellInsert,
    CellSink
  } cell_op_e;

  typedef struct packed {
    cell_op_e                     op;
    logic signed [ScoreBits-1:0]  key_score;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StExec,
    StMod,
    StWalk,
    StPick,
    StSink,
    StDone
  } state_e;

endpackage

[design/rtst_cell.sv]
// one table cell: holds one entry and shifts with its neighbours
module rtst_cell #(
  parameter int IDX = 0,
  parameter int IDW = 16,
  parameter int CW  = 5,
  parameter int IW  = 4
) (
  input  logic                                   clk_i,
  input  rtst_pkg::cell_ctrl_t                   ctrl_i,
  input  logic [IDW-1:0]                         key_id_i,
  input  logic [CW-1:0]                          lim_i,
  input  logic [IW-1:0]                          pos_i,
  input  logic signed [rtst_pkg::ScoreBits-1:0]  prev_score_i,
  input  logic [IDW-1:0]                         prev_id_i,
  input  logic                                   prev_flag_i,
  input  logic signed [rtst_pkg::ScoreBits-1:0]  next_score_i,
  input  logic [IDW-1:0]                         next_id_i,
  input  logic                                   next_flag_i,
  output logic                                   flag_o,
  output logic                                   eq_o,
  output logic signed [rtst_pkg::ScoreBits-1:0]  score_o,
  output logic [IDW-1:0]                         id_o
);

  localparam logic [CW:0] MyIdx = (CW+1)'(IDX);

  logic signed [rtst_pkg::ScoreBits-1:0] score_q, score_d;
  logic [IDW-1:0]                        id_q, id_d;
  logic                                  in_lim;
  logic [CW:0]                           pos_ext;

  assign in_lim  = MyIdx < {1'b0, lim_i};
  assign pos_ext = (CW+1)'(pos_i);
  assign eq_o    = in_lim && (score_q == ctrl_i.key_score);

  always_comb begin
    case (ctrl_i.op)
      rtst_pkg::CellInsert: flag_o = in_lim && (score_q >= ctrl_i.key_score);
      rtst_pkg::CellSink:   flag_o = (MyIdx > pos_ext) && in_lim &&
                                     (score_q > ctrl_i.key_score);
      default:              flag_o = 1'b0;
    endcase
  end

  always_comb begin
    score_d = score_q;
    id_d    = id_q;
    case (ctrl_i.op)
      rtst_pkg::CellInsert: begin
        // entries at or above the key stay, the slot below takes the key
        if (!flag_o && prev_flag_i) begin
          score_d = ctrl_i.key_score;
          id_d    = key_id_i;
        end else if (!flag_o) begin
          score_d = prev_score_i;
          id_d    = prev_id_i;
        end
      end
      rtst_pkg::CellSink: begin
        if (MyIdx >= pos_ext) begin
          if (next_flag_i) begin
            score_d = next_score_i;
            id_d    = next_id_i;
          end else if ((MyIdx == pos_ext) || flag_o) begin
            score_d = ctrl_i.key_score;
            id_d    = key_id_i;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_d;
    id_q    <= id_d;
  end

  assign score_o = score_q;
  assign id_o    = id_q;

endmodule

[design/rtst_remdiv.sv]
// bit-serial restoring remainder unit, one dividend bit a cycle
module rtst_remdiv #(
  parameter int DW = 31,
  parameter int VW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          go_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [VW-1:0] rem_o
);

  localparam int CNTW = $clog2(DW + 1);

  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;
  logic [DW-1:0]   num_q, num_d;
  logic [VW-1:0]   div_q, div_d;
  logic [VW-1:0]   rem_q, rem_d;
  logic [VW:0]     shifted;
  logic [VW:0]     diff;
  logic            ge;

  assign shifted = {rem_q, num_q[DW-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign ge      = shifted >= {1'b0, div_q};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    num_d  = num_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (go_i) begin
      cnt_d = CNTW'(DW);
      num_d = dividend_i;
      div_d = divisor_i;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      num_d  = {num_q[DW-2:0], 1'b0};
      rem_d  = ge ? diff[VW-1:0] : shifted[VW-1:0];
      done_d = (cnt_q == CNTW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[design/ranked_topk_score_table.sv]
// top level of the ranked top-k score table
//
// Keeps up to MAX_ENTRIES (id, score) entries sorted highest first in a row
// of cells. A request is taken when start_i is high and busy_o low; its one
// result appears for a single cycle with done_o high and cannot be held off,
// so the receiver must take it then. For add and load the request passes
// through a read state, which reads the lowest entry and matches the score
// against every held entry, and an execute state, in which the cells below
// the insertion point shift in parallel when the entry is kept, before the
// result. Select answers fresh or picks an entry: a bit-serial remainder
// unit works out the triangular pick weight while the fresh percent comes
// from a reciprocal multiplication by the constant 100, the rank walk then
// passes one rank per cycle (at most held entries - 1), and an optional
// decay sinks the picked entry in one parallel shift. An unknown command
// answers in the next cycle.
// Configuration is written through cfg_we_i with no wait and must only be
// written while busy_o is low. The stores have no reset; only entries below
// the held count are ever used.
module ranked_topk_score_table #(
  parameter int MAX_ENTRIES = 16,
  parameter int ID_BITS     = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic [1:0]                             cmd_i,
  input  logic [ID_BITS-1:0]                     entry_id_i,
  input  logic signed [rtst_pkg::ScoreBits-1:0]  score_i,
  input  logic [rtst_pkg::RandBits-1:0]          rand_chance_i,
  input  logic [rtst_pkg::RandBits-1:0]          rand_pick_i,
  input  logic                                   cfg_we_i,
  input  logic [1:0]                             cfg_idx_i,
  input  logic [rtst_pkg::CfgWidth-1:0]          cfg_data_i,
  output logic                                   done_o,
  output logic                                   kept_o,
  output logic                                   evict_valid_o,
  output logic [ID_BITS-1:0]                     evict_id_o,
  output logic                                   fresh_o,
  output logic                                   pick_valid_o,
  output logic [ID_BITS-1:0]                     pick_id_o,
  output logic                                   best_valid_o,
  output logic [ID_BITS-1:0]                     best_id_o,
  output logic signed [rtst_pkg::ScoreBits-1:0]  best_score_o,
  output logic [$clog2(MAX_ENTRIES+1)-1:0]       entry_count_o
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int TW = $clog2(MAX_ENTRIES * (MAX_ENTRIES + 1) / 2 + 1);
  localparam int LW = (CW > 5) ? CW : 5;
  localparam int SB = rtst_pkg::ScoreBits;

  // state and configuration
  rtst_pkg::state_e state_q, state_d;
  logic [4:0]       cap_q;
  logic [6:0]       fresh_chance_q;
  logic             decay_q;
  logic [CW-1:0]    cnt_q;

  // latched request
  logic [1:0]              cmd_q;
  logic [ID_BITS-1:0]      id_q;
  logic signed [SB-1:0]    s_q;
  logic [rtst_pkg::RandBits-1:0] rc_q;

  // read port of the row at one chosen position
  logic [IW-1:0]           sel_q;
  logic signed [SB-1:0]    rd_score_q;
  logic [ID_BITS-1:0]      rd_id_q;
  logic                    eq_q;

  // rank walk
  logic [TW-1:0]           p_q;
  logic [CW-1:0]           w_q;
  logic [IW-1:0]           pos_q;

  // result flags
  logic                    kept_q, evict_valid_q, fresh_q, pick_valid_q;
  logic [ID_BITS-1:0]      evict_id_q, pick_id_q;

  // cell row wiring
  rtst_pkg::cell_ctrl_t    ctrl;
  logic [ID_BITS-1:0]      key_id;
  logic [CW-1:0]           lim;
  logic signed [SB-1:0]    cell_score [MAX_ENTRIES];
  logic [ID_BITS-1:0]      cell_id    [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]  cell_flag;
  logic [MAX_ENTRIES-1:0]  cell_eq;

  // remainder of the pick weight and of the fresh percent
  logic                    rem_go;
  logic                    pick_done;
  logic [6:0]              chance_rem;
  logic [TW-1:0]           pick_rem;
  logic [2*CW-1:0]         cnt_wide;
  logic [2*CW-1:0]         tri_wide;
  logic [62:0]             recip_prod;
  logic [24:0]             quot_q;
  logic [6:0]              quot_x100;

  // insert decision
  logic                    accept;
  logic [LW-1:0]           lim_eff;
  logic [LW-1:0]           cnt_ext;
  logic                    full;
  logic                    beats_low;
  logic                    guard_ok;
  logic                    may_ins;
  logic                    do_ins;
  logic [CW-1:0]           ins_lim;
  logic                    walk_step;
  logic                    is_fresh;
  logic signed [SB-1:0]    halved;
  logic signed [SB-1:0]    mux_score;
  logic [ID_BITS-1:0]      mux_id;

  assign accept = start_i && (state_q == rtst_pkg::StIdle);
  assign busy_o = state_q != rtst_pkg::StIdle;

  // capacity clamped to 1 .. MAX_ENTRIES
  always_comb begin
    lim_eff = LW'(cap_q);
    if (cap_q == '0) begin
      lim_eff = LW'(1);
    end else if (LW'(cap_q) > LW'(MAX_ENTRIES)) begin
      lim_eff = LW'(MAX_ENTRIES);
    end
  end

  assign cnt_ext   = LW'(cnt_q);
  assign full      = !((cnt_ext < lim_eff) && (cnt_ext < LW'(MAX_ENTRIES)));
  assign beats_low = s_q > rd_score_q;
  assign guard_ok  = (cnt_q == '0) || (beats_low && !eq_q);
  assign may_ins   = (cmd_q == rtst_pkg::CmdLoad) || guard_ok;
  assign do_ins    = may_ins && (!full || beats_low);
  // a full table drops its lowest entry, so that entry's row is free
  assign ins_lim   = full ? (cnt_q - 1'b1) : cnt_q;
  assign walk_step = p_q >= TW'(w_q);
  assign is_fresh  = (chance_rem < fresh_chance_q) || (cnt_q == '0);
  // halving rounds toward zero
  assign halved    = (rd_score_q + $signed(SB'(rd_score_q[SB-1]))) >>> 1;

  assign cnt_wide = (2*CW)'(cnt_q);
  assign tri_wide = (cnt_wide * (cnt_wide + 1'b1)) >> 1;

  // quotient by 100 through the reciprocal, the remainder needs low bits only
  assign recip_prod = 63'(rc_q) * 63'(rtst_pkg::FreshRecip);
  assign quot_x100  = 7'(quot_q * 25'(rtst_pkg::FreshRange));
  assign chance_rem = rc_q[6:0] - quot_x100;

  // single read at the chosen position
  always_comb begin
    mux_score = cell_score[0];
    mux_id    = cell_id[0];
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (sel_q == IW'(i)) begin
        mux_score = cell_score[i];
        mux_id    = cell_id[i];
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rtst_pkg::StIdle: begin
        if (start_i) begin
          if (cmd_i == rtst_pkg::CmdAdd || cmd_i == rtst_pkg::CmdLoad) begin
            state_d = rtst_pkg::StRead;
          end else if (cmd_i == rtst_pkg::CmdSelect) begin
            state_d = rtst_pkg::StMod;
          end else begin
            state_d = rtst_pkg::StDone;
          end
        end
      end
      rtst_pkg::StRead: state_d = rtst_pkg::StExec;
      rtst_pkg::StExec: state_d = rtst_pkg::StDone;
      rtst_pkg::StMod: begin
        if (pick_done) begin
          state_d = is_fresh ? rtst_pkg::StDone : rtst_pkg::StWalk;
        end
      end
      rtst_pkg::StWalk: begin
        if (!walk_step) begin
          state_d = rtst_pkg::StPick;
        end
      end
      rtst_pkg::StPick: state_d = rtst_pkg::StSink;
      rtst_pkg::StSink: state_d = rtst_pkg::StDone;
      rtst_pkg::StDone: state_d = rtst_pkg::StIdle;
      default:          state_d = rtst_pkg::StIdle;
    endcase
  end

  // cell row control and unit start
  always_comb begin
    ctrl.op        = rtst_pkg::CellHold;
    ctrl.key_score = s_q;
    key_id         = id_q;
    lim            = cnt_q;
    rem_go         = 1'b0;
    done_o         = 1'b0;
    case (state_q)
      rtst_pkg::StIdle: rem_go = accept && (cmd_i == rtst_pkg::CmdSelect);
      rtst_pkg::StExec: begin
        ctrl.op = do_ins ? rtst_pkg::CellInsert : rtst_pkg::CellHold;
        lim     = ins_lim;
      end
      rtst_pkg::StSink: begin
        ctrl.op        = decay_q ? rtst_pkg::CellSink : rtst_pkg::CellHold;
        ctrl.key_score = halved;
        key_id         = rd_id_q;
      end
      rtst_pkg::StDone: done_o = 1'b1;
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= rtst_pkg::StIdle;
      cap_q          <= rtst_pkg::CapacityReset;
      fresh_chance_q <= rtst_pkg::FreshChanceReset;
      decay_q        <= 1'b0;
      cnt_q          <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rtst_pkg::CfgCapacity:    cap_q          <= cfg_data_i[4:0];
          rtst_pkg::CfgFreshChance: fresh_chance_q <= cfg_data_i;
          rtst_pkg::CfgDecayMode:   decay_q        <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      if (state_q == rtst_pkg::StExec && do_ins && !full) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // request and result registers
  always_ff @(posedge clk_i) begin
    rd_score_q <= mux_score;
    rd_id_q    <= mux_id;
    eq_q       <= |cell_eq;
    quot_q     <= recip_prod[62:38];
    case (state_q)
      rtst_pkg::StIdle: begin
        if (start_i) begin
          cmd_q         <= cmd_i;
          id_q          <= entry_id_i;
          s_q           <= score_i;
          rc_q          <= rand_chance_i;
          sel_q         <= IW'(cnt_q - 1'b1);
          kept_q        <= 1'b0;
          evict_valid_q <= 1'b0;
          evict_id_q    <= '0;
          fresh_q       <= 1'b0;
          pick_valid_q  <= 1'b0;
          pick_id_q     <= '0;
        end
      end
      rtst_pkg::StExec: begin
        kept_q        <= do_ins;
        evict_valid_q <= may_ins && full;
        if (may_ins && full) begin
          evict_id_q <= beats_low ? rd_id_q : id_q;
        end
      end
      rtst_pkg::StMod: begin
        if (pick_done) begin
          fresh_q <= is_fresh;
          p_q     <= pick_rem;
          w_q     <= cnt_q;
          pos_q   <= '0;
        end
      end
      rtst_pkg::StWalk: begin
        if (walk_step) begin
          p_q   <= p_q - TW'(w_q);
          w_q   <= w_q - 1'b1;
          pos_q <= pos_q + 1'b1;
        end else begin
          sel_q <= pos_q;
        end
      end
      rtst_pkg::StSink: begin
        pick_valid_q <= 1'b1;
        pick_id_q    <= rd_id_q;
      end
      default: begin
      end
    endcase
  end

  // row of cells, each handing entries to its neighbours
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic signed [SB-1:0] prev_score, next_score;
    logic [ID_BITS-1:0]   prev_id, next_id;
    logic                 prev_flag, next_flag;

    if (g == 0) begin : g_first
      assign prev_score = ctrl.key_score;
      assign prev_id    = key_id;
      assign prev_flag  = 1'b1;
    end else begin : g_mid
      assign prev_score = cell_score[g-1];
      assign prev_id    = cell_id[g-1];
      assign prev_flag  = cell_flag[g-1];
    end

    if (g == MAX_ENTRIES - 1) begin : g_last
      assign next_score = ctrl.key_score;
      assign next_id    = key_id;
      assign next_flag  = 1'b0;
    end else begin : g_inner
      assign next_score = cell_score[g+1];
      assign next_id    = cell_id[g+1];
      assign next_flag  = cell_flag[g+1];
    end

    rtst_cell #(
      .IDX(g),
      .IDW(ID_BITS),
      .CW (CW),
      .IW (IW)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .key_id_i     (key_id),
      .lim_i        (lim),
      .pos_i        (sel_q),
      .prev_score_i (prev_score),
      .prev_id_i    (prev_id),
      .prev_flag_i  (prev_flag),
      .next_score_i (next_score),
      .next_id_i    (next_id),
      .next_flag_i  (next_flag),
      .flag_o       (cell_flag[g]),
      .eq_o         (cell_eq[g]),
      .score_o      (cell_score[g]),
      .id_o         (cell_id[g])
    );
  end

  // triangular pick weight, divisor varies with the held count
  rtst_remdiv #(
    .DW(rtst_pkg::RandBits),
    .VW(TW)
  ) u_pick (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (rem_go),
    .dividend_i (rand_pick_i),
    .divisor_i  (tri_wide[TW-1:0]),
    .done_o     (pick_done),
    .rem_o      (pick_rem)
  );

  // result ports, valid while done_o is high
  assign kept_o        = kept_q;
  assign evict_valid_o = evict_valid_q;
  assign evict_id_o    = evict_id_q;
  assign fresh_o       = fresh_q;
  assign pick_valid_o  = pick_valid_q;
  assign pick_id_o     = pick_id_q;
  assign best_valid_o  = cnt_q != '0;
  assign best_id_o     = (cnt_q != '0) ? cell_id[0] : '0;
  assign best_score_o  = (cnt_q != '0) ? cell_score[0] : '0;
  assign entry_count_o = cnt_q;

endmodule
